@@ rtl/inca_pkg.sv @@
// shared constants and fixed-point helpers for the inverse normal cdf unit
package inca_pkg;

  localparam int TAG_W         = 2;
  localparam int LOG_FRAC_BITS = 27;
  localparam int ARG_W         = 62;
  localparam int ISQ_ITERS     = 31;
  localparam int QUO_W         = 32;
  localparam int POLY_W        = 40;

  localparam logic [31:0] LN2_Q31 = 32'h58B9_0BFC;
  localparam logic [31:0] Z_MIN   = 32'h8000_0000;

  localparam logic [63:0] C0_WIDE = (64'd2515517 * 64'd268435456 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] C1_WIDE = (64'd802853 * 64'd268435456 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] C2_WIDE = (64'd10328 * 64'd268435456 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] D1_WIDE = (64'd1432788 * 64'd268435456 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] D2_WIDE = (64'd189269 * 64'd268435456 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] D3_WIDE = (64'd1308 * 64'd268435456 + 64'd500000) / 64'd1000000;

  localparam logic [POLY_W-1:0] C0_Q28  = POLY_W'(C0_WIDE);
  localparam logic [POLY_W-1:0] C1_Q28  = POLY_W'(C1_WIDE);
  localparam logic [POLY_W-1:0] C2_Q28  = POLY_W'(C2_WIDE);
  localparam logic [POLY_W-1:0] D1_Q28  = POLY_W'(D1_WIDE);
  localparam logic [POLY_W-1:0] D2_Q28  = POLY_W'(D2_WIDE);
  localparam logic [POLY_W-1:0] D3_Q28  = POLY_W'(D3_WIDE);
  localparam logic [POLY_W-1:0] ONE_Q28 = POLY_W'(64'd268435456);

  // q28 times q28, rounded half up
  function automatic logic [POLY_W-1:0] mul_q28(input logic [POLY_W-1:0] a,
                                                input logic [31:0] b);
    logic [71:0] p;
    p = ({32'b0, a} * {40'b0, b}) + (72'd1 << 27);
    return p[POLY_W+27:28];
  endfunction

endpackage

@@ rtl/inverse_normal_cdf_approx_unit.sv @@
// top level: inverse normal cdf by rational approximation, fully pipelined
//
//   channel | signals                      | payload
//   input   | in_valid / in_stall          | u (32 bit unsigned fraction)
//   output  | out_valid / out_stall        | z (signed q3.28), saturated
//
// one beat in per clock unless stalled; the pipe is 28 log stages (normalize and 27 squarings),
// 32 root stages, 32 quotient stages, plus input, scale, polynomial and output
// registers. the whole pipe advances together; it holds when the output beat
// is stalled, and in_stall follows that. reset clears only the valid bits.
module inverse_normal_cdf_approx_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] u,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] z,
  output logic        saturated
);

  localparam int TW = inca_pkg::TAG_W;
  localparam int PW = inca_pkg::POLY_W;
  localparam int QW = inca_pkg::QUO_W;

  // pipe moves unless a finished beat is waiting
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input register
  logic        vld_i;
  logic [31:0] u_i;

  always_ff @(posedge clk) begin
    if (rst) vld_i <= 1'b0;
    else if (adv) vld_i <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) u_i <= u;
  end

  // tail fold: tag is {lower half, zero input}
  logic          lower_c, zero_c;
  logic [31:0]   m_c;
  assign zero_c  = (u_i == 32'd0);
  assign lower_c = !u_i[31];
  assign m_c     = lower_c ? u_i : 32'd0 - u_i;

  logic          lg_vld;
  logic [31:0]   l2;
  logic [TW-1:0] lg_tag;

  inca_log2 #(.TAG_W(TW)) u_log2 (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (vld_i),
    .m       (m_c),
    .in_tag  ({lower_c, zero_c}),
    .out_vld (lg_vld),
    .l2      (l2),
    .out_tag (lg_tag)
  );

  // -2 ln q = (32 - log2 m) * 2 ln2, in q27
  logic [32:0]   w_c;
  logic [64:0]   lp_c;
  logic          sc_vld;
  logic [32:0]   l27;
  logic [TW-1:0] sc_tag;

  assign w_c  = (33'd1 << 32) - {1'b0, l2};
  assign lp_c = ({32'b0, w_c} * {33'b0, inca_pkg::LN2_Q31}) + (65'd1 << 29);

  always_ff @(posedge clk) begin
    if (rst) sc_vld <= 1'b0;
    else if (adv) sc_vld <= lg_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l27    <= lp_c[62:30];
      sc_tag <= lg_tag;
    end
  end

  // t = sqrt in q28
  logic          sq_vld;
  logic [31:0]   t;
  logic [TW-1:0] sq_tag;

  inca_isqrt #(.TAG_W(TW)) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (sc_vld),
    .v       ({l27, 29'b0}),
    .in_tag  (sc_tag),
    .out_vld (sq_vld),
    .root    (t),
    .out_tag (sq_tag)
  );

  // horner, numerator and denominator side by side
  logic          p1_vld, p2_vld, p3_vld, p4_vld;
  logic [PW-1:0] a1, b1, num2, b2, num3, den3, den4;
  logic [31:0]   t1, t2, t3, t4;
  logic [TW-1:0] tag1, tag2, tag3, tag4;
  logic [63:0]   nn4;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
    end else if (adv) begin
      p1_vld <= sq_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1   <= inca_pkg::mul_q28(inca_pkg::C2_Q28, t) + inca_pkg::C1_Q28;
      b1   <= inca_pkg::mul_q28(inca_pkg::D3_Q28, t) + inca_pkg::D2_Q28;
      t1   <= t;
      tag1 <= sq_tag;
      num2 <= inca_pkg::mul_q28(a1, t1) + inca_pkg::C0_Q28;
      b2   <= inca_pkg::mul_q28(b1, t1) + inca_pkg::D1_Q28;
      t2   <= t1;
      tag2 <= tag1;
      num3 <= num2;
      den3 <= inca_pkg::mul_q28(b2, t2) + inca_pkg::ONE_Q28;
      t3   <= t2;
      tag3 <= tag2;
      // dividend with half-divisor rounding term
      nn4  <= {num3[35:0], 28'b0} + 64'(den3 >> 1);
      den4 <= den3;
      t4   <= t3;
      tag4 <= tag3;
    end
  end

  // restoring divide, one quotient bit per stage
  logic          dv_vld [0:QW];
  logic [PW-1:0] dv_r   [0:QW];
  logic [QW-1:0] dv_q   [0:QW];
  logic [63:0]   dv_n   [0:QW];
  logic [PW-1:0] dv_d   [0:QW];
  logic [31:0]   dv_t   [0:QW];
  logic [TW-1:0] dv_tag [0:QW];

  assign dv_vld[0] = p4_vld;
  assign dv_r[0]   = PW'(nn4[63:32]);
  assign dv_q[0]   = '0;
  assign dv_n[0]   = nn4;
  assign dv_d[0]   = den4;
  assign dv_t[0]   = t4;
  assign dv_tag[0] = tag4;

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [PW-1:0] rs;
    logic          ge;
    assign rs = {dv_r[i][PW-2:0], dv_n[i][QW-1-i]};
    assign ge = rs >= dv_d[i];
    always_ff @(posedge clk) begin
      if (rst) dv_vld[i+1] <= 1'b0;
      else if (adv) dv_vld[i+1] <= dv_vld[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[i+1]   <= ge ? rs - dv_d[i] : rs;
        dv_q[i+1]   <= {dv_q[i][QW-2:0], ge};
        dv_n[i+1]   <= dv_n[i];
        dv_d[i+1]   <= dv_d[i];
        dv_t[i+1]   <= dv_t[i];
        dv_tag[i+1] <= dv_tag[i];
      end
    end
  end

  // g = t - ratio, sign by half, clamp on zero input
  logic [33:0] g_c, zs_c;
  logic        lower_o, zero_o;
  assign lower_o = dv_tag[QW][1];
  assign zero_o  = dv_tag[QW][0];
  assign g_c     = {2'b0, dv_t[QW]} - {2'b0, dv_q[QW]};
  assign zs_c    = lower_o ? 34'd0 - g_c : g_c;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv_vld[QW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z         <= zero_o ? inca_pkg::Z_MIN : zs_c[31:0];
      saturated <= zero_o;
    end
  end

`ifndef SYNTH
  // clamp code comes with the flag, and only with it
  a_sat_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> z == inca_pkg::Z_MIN)
    else $error("saturated beat without clamp value");

  a_no_false_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && !saturated |-> z != inca_pkg::Z_MIN)
    else $error("clamp value without saturated flag");

  // a held output freezes the whole pipe, input included
  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(z) && $stable(vld_i))
    else $error("pipe moved while output held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

@@ rtl/inca_log2.sv @@
// pipelined log2 in q27: normalize, then one squaring per stage
module inca_log2 #(
  parameter int TAG_W = inca_pkg::TAG_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_vld,
  input  logic [31:0]      m,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [31:0]      l2,
  output logic [TAG_W-1:0] out_tag
);

  localparam int NS = inca_pkg::LOG_FRAC_BITS;

  logic             vld  [0:NS];
  logic [31:0]      x    [0:NS];
  logic [NS-1:0]    frac [0:NS];
  logic [4:0]       e    [0:NS];
  logic [TAG_W-1:0] tag  [0:NS];

  logic [4:0]  e_c;
  logic [31:0] x_c;

  // leading one position
  always_comb begin
    e_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) e_c = 5'(i);
    end
    x_c = m << (5'd31 - e_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NS; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
      for (int k = 0; k < NS; k++) vld[k+1] <= vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x[0]    <= x_c;
      frac[0] <= '0;
      e[0]    <= e_c;
      tag[0]  <= in_tag;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] s;
    assign sq = {32'b0, x[k]} * {32'b0, x[k]};
    assign s  = sq[63:31];
    always_ff @(posedge clk) begin
      if (adv) begin
        x[k+1]    <= s[32] ? s[32:1] : s[31:0];
        frac[k+1] <= {frac[k][NS-2:0], s[32]};
        e[k+1]    <= e[k];
        tag[k+1]  <= tag[k];
      end
    end
  end

  assign out_vld = vld[NS];
  assign l2      = {e[NS], frac[NS]};
  assign out_tag = tag[NS];

endmodule

@@ rtl/inca_isqrt.sv @@
// pipelined integer square root, one result bit per stage
module inca_isqrt #(
  parameter int TAG_W = inca_pkg::TAG_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_vld,
  input  logic [inca_pkg::ARG_W-1:0] v,
  input  logic [TAG_W-1:0]         in_tag,
  output logic                     out_vld,
  output logic [31:0]              root,
  output logic [TAG_W-1:0]         out_tag
);

  localparam int AW = inca_pkg::ARG_W;
  localparam int NI = inca_pkg::ISQ_ITERS;

  logic             vld [0:NI];
  logic [AW-1:0]    vr  [0:NI];
  logic [AW-1:0]    rr  [0:NI];
  logic [TAG_W-1:0] tag [0:NI];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NI; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
      for (int k = 0; k < NI; k++) vld[k+1] <= vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vr[0]  <= v;
      rr[0]  <= '0;
      tag[0] <= in_tag;
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_it
    localparam logic [AW-1:0] B = AW'(1) << (AW - 2 - 2 * i);
    logic [AW:0] sum;
    logic        take;
    assign sum  = {1'b0, rr[i]} + {1'b0, B};
    assign take = {1'b0, vr[i]} >= sum;
    always_ff @(posedge clk) begin
      if (adv) begin
        vr[i+1]  <= take ? AW'({1'b0, vr[i]} - sum) : vr[i];
        rr[i+1]  <= take ? (rr[i] >> 1) + B : rr[i] >> 1;
        tag[i+1] <= tag[i];
      end
    end
  end

  assign out_vld = vld[NI];
  assign root    = rr[NI][31:0];
  assign out_tag = tag[NI];

endmodule

@@ bench/inverse_normal_cdf_approx_unit_tb.sv @@
// testbench for the inverse normal cdf unit: directed and random beats against a bit-exact predictor
module inverse_normal_cdf_approx_unit_tb;

  localparam int LATENCY = 99;
  localparam logic [31:0] HALF_U = 32'h8000_0000;

  // coefficients in q28, rounded to nearest from millionths
  localparam logic [63:0] NUM_C0 = (64'd2515517 * 64'd268435456 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] NUM_C1 = (64'd802853 * 64'd268435456 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] NUM_C2 = (64'd10328 * 64'd268435456 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] DEN_D1 = (64'd1432788 * 64'd268435456 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] DEN_D2 = (64'd189269 * 64'd268435456 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] DEN_D3 = (64'd1308 * 64'd268435456 + 64'd500000) / 64'd1000000;
  localparam logic [63:0] FIX_ONE = 64'd268435456;
  localparam logic [63:0] LN2_FIX = 64'h58B9_0BFC;

  typedef struct packed {
    logic [31:0] z;
    logic        saturated;
  } quantile_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] u = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] z;
  logic        saturated;

  quantile_t expected_q[$];
  int        error_count = 0;
  int        beats_sent = 0;
  int        beats_checked = 0;
  int        saturated_seen = 0;
  bit        idle_enable = 1'b0;   // random gaps on both sides
  bit        hold_output = 1'b0;   // long receiver hold-off request
  int        hold_cycles = 0;

  inverse_normal_cdf_approx_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .u(u),
    .out_valid(out_valid), .out_stall(out_stall), .z(z), .saturated(saturated)
  );

  always #5 clk = ~clk;

  // q28 product rounded half up
  function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b + (128'd1 << 27);
    return p[91:28];
  endfunction

  // log2 of m in q27: integer part from the top set bit, fraction by repeated squaring
  function automatic logic [63:0] log2_fix(input logic [31:0] m);
    int unsigned e;
    logic [63:0] x, frac;
    e = 0;
    frac = '0;
    while (e < 31 && (m >> (e + 1)) != 0) e++;
    x = 64'(m) << (31 - e);
    for (int k = 0; k < 27; k++) begin
      x = (x * x) >> 31;
      frac = frac << 1;
      if (x >= (64'd1 << 32)) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e) << 27) | frac;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic quantile_t predict_quantile(input logic [31:0] uin);
    quantile_t r;
    logic        lower;
    logic [31:0] m;
    logic [63:0] w, l27, t, num, den, ratio, g;
    if (uin == 0) begin
      r.z = 32'h8000_0000;
      r.saturated = 1'b1;
      return r;
    end
    lower = uin < HALF_U;
    m = lower ? uin : (32'd0 - uin);
    w = (64'd32 << 27) - log2_fix(m);
    l27 = (w * LN2_FIX + (64'd1 << 29)) >> 30;
    t = floor_sqrt(l27 << 29);
    num = fix_mul(fix_mul(NUM_C2, t) + NUM_C1, t) + NUM_C0;
    den = fix_mul(fix_mul(fix_mul(DEN_D3, t) + DEN_D2, t) + DEN_D1, t) + FIX_ONE;
    ratio = ((num << 28) + (den >> 1)) / den;
    g = t - ratio;
    if (lower) g = -g;
    r.z = g[31:0];
    r.saturated = 1'b0;
    return r;
  endfunction

  // one beat in, with optional random gap before it; payload held while stalled,
  // valid left high so the next beat can follow without a gap
  task automatic send_beat(input logic [31:0] value);
    if (idle_enable) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    u <= value;
    expected_q = {expected_q, predict_quantile(value)};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // receiver stall: random when enabled, solid during a hold-off stretch
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_output && hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_enable) begin
      out_stall <= ($urandom_range(99) < 20);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin
    quantile_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected beat: z=%h saturated=%b", z, saturated);
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        beats_checked++;
        if (saturated) saturated_seen++;
        if (z !== exp_r.z) begin
          $error("z: expected %h actual %h", exp_r.z, z);
          error_count++;
        end
        if (saturated !== exp_r.saturated) begin
          $error("saturated: expected %b actual %b", exp_r.saturated, saturated);
          error_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // extremes, the zero input, the exact half and its neighbors, tail edges
  task automatic test_directed();
    logic [31:0] pts[$];
    pts = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h4000_0000,
            32'hC000_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h5555_5555,
            32'hAAAA_AAAA, 32'h0000_0100, 32'h0, 32'h1000_0000, 32'hF000_0000,
            32'h0123_4567};
    foreach (pts[i]) send_beat(pts[i]);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // back to back with no gaps at all
  task automatic test_streaming(input int n);
    idle_enable = 1'b0;
    for (int i = 0; i < n; i++) send_beat($urandom());
    in_valid <= 1'b0;
  endtask

  // random values with random gaps on both sides; some tail-weighted
  task automatic test_random(input int n);
    logic [31:0] v;
    idle_enable = 1'b1;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: v = $urandom() >> $urandom_range(31);        // small u, lower tail
        1: v = ~($urandom() >> $urandom_range(31));     // near one, upper tail
        default: v = $urandom();
      endcase
      if ($urandom_range(199) == 0) v = '0;
      send_beat(v);
    end
    in_valid <= 1'b0;
    idle_enable = 1'b0;
  endtask

  // receiver holds off long enough that the pipe fills and stalls the sender
  task automatic test_backpressure();
    idle_enable = 1'b0;
    @(negedge clk);
    hold_cycles = 3 * LATENCY;
    hold_output = 1'b1;
    for (int i = 0; i < 2 * LATENCY; i++) send_beat($urandom());
    in_valid <= 1'b0;
    wait (hold_cycles == 0);
    hold_output = 1'b0;
    wait_drained();   // sender pause until everything has come back
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_streaming(300);
    test_backpressure();
    test_random(1500);
    wait_drained();
    repeat (LATENCY + 10) @(negedge clk);
    $display("covered %0d beats, %0d checked, %0d saturated results",
             beats_sent, beats_checked, saturated_seen);
    $display("phases: directed, streaming, long receiver hold-off, random gaps");
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("inverse_normal_cdf_approx_unit verification clean");
    end else begin
      $display("inverse_normal_cdf_approx_unit verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("inverse_normal_cdf_approx_unit verification failed");
    $finish;
  end

endmodule
